### sv/inverse_affine_warp_sampler_core_defines.svh
// Assertion macros used by the sampler back end (iaws_back).
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef INVERSE_AFFINE_WARP_SAMPLER_CORE_DEFINES_SVH
`define INVERSE_AFFINE_WARP_SAMPLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IAWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define IAWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IAWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define IAWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### sv/iaws_pkg.sv
// Shared constants, types and helpers for the affine warp sampler.
// No dependencies.
package iaws_pkg;
	localparam int MAX_SRC_WIDTH  = 128;
	localparam int MAX_SRC_HEIGHT = 128;
	localparam int OUT_ROWS       = 48;
	localparam int OUT_COLS       = 40;
	localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int SIZE_W         = $clog2(STORE_DEPTH + 1);
	localparam int COL_W          = $clog2(MAX_SRC_WIDTH);
	localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);
	localparam int QB             = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int COEF_W         = 32;
	localparam int DIM_W          = 8;
	localparam int PIX_W          = 8;
	localparam int OROW_W         = 6;
	localparam int OCOL_W         = 6;
	localparam int ACC_W          = 67;
	localparam int IDX_W          = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_A11, REG_A12, REG_B1, REG_A21, REG_A22, REG_B2, REG_SRC_W, REG_SRC_H
	} reg_idx_t;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef struct packed {
		logic [COEF_W-1:0] a11;
		logic [COEF_W-1:0] a12;
		logic [COEF_W-1:0] b1;
		logic [COEF_W-1:0] a21;
		logic [COEF_W-1:0] a22;
		logic [COEF_W-1:0] b2;
		logic [COL_W:0]    eff_w;
		logic [ROW_W:0]    eff_h;
	} cfg_t;

	typedef struct packed {
		req_t              kind;
		logic [PIX_W-1:0]  pixel;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
	} item_t;

	function automatic logic [COL_W:0] sat_w(logic [DIM_W-1:0] v);
		logic [COL_W:0] r;
		if (v == '0) r = (COL_W+1)'(1);
		else if (int'(v) > MAX_SRC_WIDTH) r = (COL_W+1)'(MAX_SRC_WIDTH);
		else r = (COL_W+1)'(v);
		return r;
	endfunction

	function automatic logic [ROW_W:0] sat_h(logic [DIM_W-1:0] v);
		logic [ROW_W:0] r;
		if (v == '0) r = (ROW_W+1)'(1);
		else if (int'(v) > MAX_SRC_HEIGHT) r = (ROW_W+1)'(MAX_SRC_HEIGHT);
		else r = (ROW_W+1)'(v);
		return r;
	endfunction
endpackage

### sv/iaws_front.sv
// Front end: accepts input transactions, saturates coordinates, queues them.
// Depends on iaws_pkg.
module iaws_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [iaws_pkg::PIX_W-1:0]     pixel_in,
	input  logic [iaws_pkg::OROW_W-1:0]    out_row,
	input  logic [iaws_pkg::OCOL_W-1:0]    out_col,
	output iaws_pkg::item_t                q_item,
	output logic                           q_valid,
	input  logic                           q_pop
);
	iaws_pkg::item_t fifo_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	iaws_pkg::item_t cls;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_comb begin
		cls.kind  = iaws_pkg::req_t'(req_type);
		cls.pixel = pixel_in;
		cls.row   = (int'(out_row) > iaws_pkg::OUT_ROWS - 1) ?
			iaws_pkg::OROW_W'(iaws_pkg::OUT_ROWS - 1) : out_row;
		cls.col   = (int'(out_col) > iaws_pkg::OUT_COLS - 1) ?
			iaws_pkg::OCOL_W'(iaws_pkg::OUT_COLS - 1) : out_col;
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### sv/iaws_back.sv
// Back end: frame store, shared multiplier, restoring divider, result register.
// Depends on iaws_pkg and inverse_affine_warp_sampler_core_defines.svh.
`include "inverse_affine_warp_sampler_core_defines.svh"
module iaws_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iaws_pkg::cfg_t                 cfg,
	input  iaws_pkg::item_t                q_item,
	input  logic                           q_valid,
	output logic                           q_pop,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [iaws_pkg::PIX_W-1:0]     pixel_out,
	output logic [iaws_pkg::COL_W-1:0]     src_col,
	output logic [iaws_pkg::ROW_W-1:0]     src_row,
	output logic                           singular_map
);
	localparam int AW = iaws_pkg::ACC_W;
	localparam int QB = iaws_pkg::QB;
	localparam int BW = $clog2(QB);
	localparam logic [3:0] LAST_STEP = 4'd10;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIVSET, S_DIVIT, S_ADDR, S_READ, S_EMIT
	} state_t;

	state_t                         state_q;
	logic [3:0]                     step_q, prod_idx_q;
	logic                           prod_vld_q, sel_y_q, sing_q;
	logic [iaws_pkg::ADDR_W-1:0]    load_pos_q, addr_q;
	logic [iaws_pkg::PIX_W-1:0]     store [iaws_pkg::STORE_DEPTH];
	logic [iaws_pkg::PIX_W-1:0]     rdata_q;
	logic [iaws_pkg::OROW_W-1:0]    row_q;
	logic [iaws_pkg::OCOL_W-1:0]    col_q;
	logic signed [63:0]             prod_q;
	logic signed [AW-1:0]           det_q, nx_q, ny_q, term;
	logic [AW-1:0]                  rem_q, dabs_q, n_abs, d_abs;
	logic [QB-1:0]                  quot_q, tx_q, ty_q, limit, quot_nx;
	logic [BW-1:0]                  bit_q;
	logic signed [31:0]             mul_a, mul_b;
	logic signed [63:0]             mul_p;
	logic signed [AW-1:0]           num;
	logic                           opp, big, ge, emit_go, is_sample;
	logic [AW+QB-1:0]               trial;
	logic [iaws_pkg::SIZE_W-1:0]    size;
	logic [iaws_pkg::ADDR_W-1:0]    wpos;
	logic [iaws_pkg::ADDR_W:0]      wnext;
	logic                           we;

	assign is_sample = (q_item.kind == iaws_pkg::REQ_SAMPLE);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign we        = q_pop && !is_sample;
	assign emit_go   = !res_valid || res_ready;

	// Load addressing with wrap at the current frame size
	always_comb begin
		size  = iaws_pkg::SIZE_W'(cfg.eff_w) * iaws_pkg::SIZE_W'(cfg.eff_h);
		wpos  = (iaws_pkg::SIZE_W'(load_pos_q) >= size) ? '0 : load_pos_q;
		wnext = (iaws_pkg::ADDR_W+1)'(wpos) + (iaws_pkg::ADDR_W+1)'(1);
	end

	// Operand select for the shared 32x32 multiplier
	always_comb begin
		case (step_q)
			4'd0:    begin mul_a = $signed(cfg.a11); mul_b = $signed(cfg.a22); end
			4'd1:    begin mul_a = $signed(cfg.a21); mul_b = $signed(cfg.a12); end
			4'd2:    begin mul_a = $signed(32'(col_q)); mul_b = $signed(cfg.a22); end
			4'd3:    begin mul_a = $signed(32'(row_q)); mul_b = $signed(cfg.a12); end
			4'd4:    begin mul_a = $signed(cfg.a12); mul_b = $signed(cfg.b2); end
			4'd5:    begin mul_a = $signed(cfg.a22); mul_b = $signed(cfg.b1); end
			4'd6:    begin mul_a = $signed(32'(row_q)); mul_b = $signed(cfg.a11); end
			4'd7:    begin mul_a = $signed(32'(col_q)); mul_b = $signed(cfg.a21); end
			4'd8:    begin mul_a = $signed(cfg.a21); mul_b = $signed(cfg.b1); end
			4'd9:    begin mul_a = $signed(cfg.a11); mul_b = $signed(cfg.b2); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = mul_a * mul_b;
		term  = AW'(prod_q);
		if (prod_idx_q inside {4'd2, 4'd3, 4'd6, 4'd7}) term = term <<< 16;
	end

	// Divider setup and one restoring step
	always_comb begin
		num     = sel_y_q ? ny_q : nx_q;
		limit   = sel_y_q ? QB'(cfg.eff_h - (iaws_pkg::ROW_W+1)'(1)) :
			QB'(cfg.eff_w - (iaws_pkg::COL_W+1)'(1));
		opp     = (num == '0) || (num[AW-1] != det_q[AW-1]);
		n_abs   = num[AW-1] ? AW'(-num) : AW'(num);
		d_abs   = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);
		big     = {{QB{1'b0}}, n_abs} >= {d_abs, {QB{1'b0}}};
		trial   = {{QB{1'b0}}, dabs_q} << bit_q;
		ge      = {{QB{1'b0}}, rem_q} >= trial;
		quot_nx = quot_q | (ge ? (QB'(1) << bit_q) : '0);
	end

	always_ff @(posedge clk) begin
		if (we) store[wpos] <= q_item.pixel;
		rdata_q <= store[addr_q];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q     <= mul_p;
		prod_idx_q <= step_q;
		case (state_q)
			S_IDLE: begin
				row_q <= q_item.row;
				col_q <= q_item.col;
				det_q <= '0;
				nx_q  <= '0;
				ny_q  <= '0;
			end
			S_MUL: begin
				if (prod_vld_q) begin
					case (prod_idx_q)
						4'd0:            det_q <= det_q + term;
						4'd1:            det_q <= det_q - term;
						4'd2, 4'd4:      nx_q  <= nx_q + term;
						4'd3, 4'd5:      nx_q  <= nx_q - term;
						4'd6, 4'd8:      ny_q  <= ny_q + term;
						4'd7, 4'd9:      ny_q  <= ny_q - term;
						default:         det_q <= det_q;
					endcase
				end
			end
			S_DIVSET: begin
				rem_q  <= n_abs;
				dabs_q <= d_abs;
				quot_q <= '0;
				bit_q  <= BW'(QB - 1);
			end
			S_DIVIT: begin
				if (ge) rem_q <= rem_q - AW'(trial);
				quot_q <= quot_nx;
				bit_q  <= bit_q - BW'(1);
			end
			S_ADDR: begin
				addr_q <= iaws_pkg::ADDR_W'(
					(iaws_pkg::ADDR_W+1)'(ty_q) * (iaws_pkg::ADDR_W+1)'(cfg.eff_w) +
					(iaws_pkg::ADDR_W+1)'(tx_q));
			end
			default: ;
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			prod_vld_q   <= 1'b0;
			sel_y_q      <= 1'b0;
			sing_q       <= 1'b0;
			tx_q         <= '0;
			ty_q         <= '0;
			load_pos_q   <= '0;
			res_valid    <= 1'b0;
			pixel_out    <= '0;
			src_col      <= '0;
			src_row      <= '0;
			singular_map <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (is_sample) begin
							step_q     <= '0;
							prod_vld_q <= 1'b0;
							sel_y_q    <= 1'b0;
							state_q    <= S_MUL;
						end else begin
							load_pos_q <= (iaws_pkg::SIZE_W'(wnext) >= size) ? '0 :
								iaws_pkg::ADDR_W'(wnext);
						end
					end
				end
				S_MUL: begin
					prod_vld_q <= (step_q != LAST_STEP);
					step_q     <= step_q + 4'd1;
					if (step_q == LAST_STEP) state_q <= S_DIVSET;
				end
				S_DIVSET: begin
					if (det_q == '0) begin
						sing_q  <= 1'b1;
						tx_q    <= '0;
						ty_q    <= '0;
						state_q <= S_EMIT;
					end else begin
						sing_q <= 1'b0;
						if (opp || big) begin
							if (sel_y_q) begin
								ty_q    <= opp ? '0 : limit;
								state_q <= S_ADDR;
							end else begin
								tx_q    <= opp ? '0 : limit;
								sel_y_q <= 1'b1;
							end
						end else begin
							state_q <= S_DIVIT;
						end
					end
				end
				S_DIVIT: begin
					if (bit_q == '0) begin
						if (sel_y_q) begin
							ty_q    <= (quot_nx > limit) ? limit : quot_nx;
							state_q <= S_ADDR;
						end else begin
							tx_q    <= (quot_nx > limit) ? limit : quot_nx;
							sel_y_q <= 1'b1;
							state_q <= S_DIVSET;
						end
					end
				end
				S_ADDR: state_q <= S_READ;
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						res_valid    <= 1'b1;
						pixel_out    <= sing_q ? '0 : rdata_q;
						src_col      <= iaws_pkg::COL_W'(tx_q);
						src_row      <= iaws_pkg::ROW_W'(ty_q);
						singular_map <= sing_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IAWS_ASSERT_IMPL(a_pop_idle, clk, arst_n, q_pop, state_q == S_IDLE, "pop outside idle")
	`IAWS_ASSERT_IMPL(a_sing_zero, clk, arst_n, res_valid && singular_map, pixel_out == '0 && src_col == '0 && src_row == '0, "singular result not zero")
	`IAWS_ASSERT_NEXT(a_emit_done, clk, arst_n, state_q == S_EMIT && emit_go, state_q == S_IDLE && res_valid, "emit did not hand off")
	`IAWS_ASSERT_IMPL(a_col_range, clk, arst_n, res_valid && !singular_map, (iaws_pkg::COL_W+1)'(src_col) < cfg.eff_w, "column beyond frame")
endmodule

### sv/inverse_affine_warp_sampler_core.sv
// Sampler top. Loads: queued, then written to the frame store when popped, one per cycle
// while no sample is in progress. Samples: queue pop, the shared 32x32 multiplier, the two
// 7-step restoring divides (fewer steps when a coordinate clamps early), then address, store
// read and result register; a singular map skips the divides, address and store read.
// No item is popped until a sample's result is registered; that waits while a result is held.
// Reset: async, active low; identity map, 128x128 frame, load position 0; store not cleared.
module inverse_affine_warp_sampler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [iaws_pkg::IDX_W-1:0]     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [iaws_pkg::PIX_W-1:0]     pixel_in,
	input  logic [iaws_pkg::OROW_W-1:0]    out_row,
	input  logic [iaws_pkg::OCOL_W-1:0]    out_col,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [iaws_pkg::PIX_W-1:0]     pixel_out,
	output logic [iaws_pkg::COL_W-1:0]     src_col,
	output logic [iaws_pkg::ROW_W-1:0]     src_row,
	output logic                           singular_map
);
	logic [31:0]                 a11_q, a12_q, b1_q, a21_q, a22_q, b2_q;
	logic [iaws_pkg::DIM_W-1:0]  sw_q, sh_q;
	iaws_pkg::cfg_t              cfg;
	iaws_pkg::item_t             q_item;
	logic                        q_valid, q_pop;

	// Config writes are registered when valid; the port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a11_q <= 32'h0001_0000;
			a12_q <= '0;
			b1_q  <= '0;
			a21_q <= '0;
			a22_q <= 32'h0001_0000;
			b2_q  <= '0;
			sw_q  <= iaws_pkg::DIM_W'(128);
			sh_q  <= iaws_pkg::DIM_W'(128);
		end else if (cfg_valid && cfg_ready) begin
			case (iaws_pkg::reg_idx_t'(cfg_index))
				iaws_pkg::REG_A11:   a11_q <= cfg_data;
				iaws_pkg::REG_A12:   a12_q <= cfg_data;
				iaws_pkg::REG_B1:    b1_q  <= cfg_data;
				iaws_pkg::REG_A21:   a21_q <= cfg_data;
				iaws_pkg::REG_A22:   a22_q <= cfg_data;
				iaws_pkg::REG_B2:    b2_q  <= cfg_data;
				iaws_pkg::REG_SRC_W: sw_q  <= cfg_data[iaws_pkg::DIM_W-1:0];
				iaws_pkg::REG_SRC_H: sh_q  <= cfg_data[iaws_pkg::DIM_W-1:0];
				default:             ;
			endcase
		end
	end

	// Effective frame size saturated to 1..max
	always_comb begin
		cfg.a11   = a11_q;
		cfg.a12   = a12_q;
		cfg.b1    = b1_q;
		cfg.a21   = a21_q;
		cfg.a22   = a22_q;
		cfg.b2    = b2_q;
		cfg.eff_w = iaws_pkg::sat_w(sw_q);
		cfg.eff_h = iaws_pkg::sat_h(sh_q);
	end

	// Front: accept and classify, two-entry queue
	iaws_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.pixel_in (pixel_in),
		.out_row  (out_row),
		.out_col  (out_col),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop)
	);

	// Back: store writes, inverse map, clamp, lookup
	iaws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.pixel_out    (pixel_out),
		.src_col      (src_col),
		.src_row      (src_row),
		.singular_map (singular_map)
	);
endmodule

### tb/iaws_checker.sv
// Scoreboard for the affine warp sampler: mirrors config and frame store, predicts samples.
// Depends on iaws_pkg; instantiated beside the DUT by tb_inverse_affine_warp_sampler_core.
`timescale 1ns / 100ps
module iaws_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [iaws_pkg::IDX_W-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  pixel_in,
	input  logic [5:0]                  out_row,
	input  logic [5:0]                  out_col,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [7:0]                  pixel_out,
	input  logic [6:0]                  src_col,
	input  logic [6:0]                  src_row,
	input  logic                        singular_map,
	output int                          errors,
	output int                          pending
);
	typedef logic signed [127:0] wide_t;
	typedef struct {
		logic [7:0] pix;
		logic [6:0] col;
		logic [6:0] row;
		logic       sing;
	} sample_t;

	logic [31:0] a11, a12, b1, a21, a22, b2;
	logic [7:0]  width_reg, height_reg;
	logic [7:0]  frame [iaws_pkg::STORE_DEPTH];
	int          load_pos;
	sample_t     samples_due [$];

	function automatic int sat_dim(logic [7:0] v);
		if (v == 0) return 1;
		if (v > 128) return 128;
		return int'(v);
	endfunction

	function automatic wide_t wx(logic [31:0] v);
		return wide_t'(int'(v));
	endfunction

	// trunc(num/den) clamped to 0..lim
	function automatic int clamp_quot(wide_t num, wide_t den, int lim);
		wide_t q;
		if (num == 0 || ((num < 0) != (den < 0))) return 0;
		q = num / den;
		if (q >= lim) return lim;
		return int'(q);
	endfunction

	task automatic report(string what, int exp_v, int got_v);
		$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int      w, h, sz, r, c, tx, ty;
		wide_t   det, nx, ny;
		sample_t s;
		if (!arst_n) begin
			a11 = 32'h0001_0000; a12 = 0; b1 = 0;
			a21 = 0; a22 = 32'h0001_0000; b2 = 0;
			width_reg = 8'd128; height_reg = 8'd128;
			load_pos = 0;
			samples_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (iaws_pkg::reg_idx_t'(cfg_index))
					iaws_pkg::REG_A11: a11 = cfg_data;
					iaws_pkg::REG_A12: a12 = cfg_data;
					iaws_pkg::REG_B1: b1 = cfg_data;
					iaws_pkg::REG_A21: a21 = cfg_data;
					iaws_pkg::REG_A22: a22 = cfg_data;
					iaws_pkg::REG_B2: b2 = cfg_data;
					iaws_pkg::REG_SRC_W: width_reg = cfg_data[7:0];
					iaws_pkg::REG_SRC_H: height_reg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				w = sat_dim(width_reg);
				h = sat_dim(height_reg);
				sz = w * h;
				if (iaws_pkg::req_t'(req_type) == iaws_pkg::REQ_LOAD) begin
					// a resize can leave the write pointer past the frame end
					if (load_pos >= sz) load_pos = 0;
					frame[load_pos] = pixel_in;
					load_pos++;
					if (load_pos >= sz) load_pos = 0;
				end else begin
					r = (out_row > iaws_pkg::OUT_ROWS - 1) ? iaws_pkg::OUT_ROWS - 1 :
						int'(out_row);
					c = (out_col > iaws_pkg::OUT_COLS - 1) ? iaws_pkg::OUT_COLS - 1 :
						int'(out_col);
					det = wx(a11) * wx(a22) - wx(a21) * wx(a12);
					if (det == 0) begin
						s = '{pix: 8'd0, col: 7'd0, row: 7'd0, sing: 1'b1};
					end else begin
						nx = (wide_t'(c) * wx(a22) - wide_t'(r) * wx(a12)) * 65536
							+ wx(a12) * wx(b2) - wx(a22) * wx(b1);
						ny = (wide_t'(r) * wx(a11) - wide_t'(c) * wx(a21)) * 65536
							+ wx(a21) * wx(b1) - wx(a11) * wx(b2);
						tx = clamp_quot(nx, det, w - 1);
						ty = clamp_quot(ny, det, h - 1);
						s.pix = frame[ty * w + tx];
						s.col = 7'(tx);
						s.row = 7'(ty);
						s.sing = 1'b0;
					end
					samples_due.push_back(s);
				end
			end
			if (res_valid && res_ready) begin
				if (samples_due.size() == 0) begin
					report("unexpected result", 0, int'(pixel_out));
				end else begin
					s = samples_due.pop_front();
					if (pixel_out !== s.pix) report("pixel_out", s.pix, pixel_out);
					if (src_col !== s.col) report("src_col", s.col, src_col);
					if (src_row !== s.row) report("src_row", s.row, src_row);
					if (singular_map !== s.sing) report("singular_map", s.sing, singular_map);
				end
			end
			pending <= samples_due.size();
		end
	end
endmodule

### tb/tb_inverse_affine_warp_sampler_core.sv
// Top testbench for the affine warp sampler: clock, reset, config phases and stimulus.
// Depends on iaws_pkg, the sampler core and iaws_checker, which does all prediction.
`timescale 1ns / 100ps
module tb_inverse_affine_warp_sampler_core;
	localparam int DRAIN_CYCLES = 40;   // a bit over the worst sample latency
	localparam int NUM_PHASES   = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid, cfg_ready;
	logic [iaws_pkg::IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_ready;
	logic        req_type;
	logic [7:0]  pixel_in;
	logic [5:0]  out_row, out_col;
	logic        res_valid, res_ready;
	logic [7:0]  pixel_out;
	logic [6:0]  src_col, src_row;
	logic        singular_map;
	int          errors, pending;
	bit          quiet = 1'b0;      // no idling on either side once set

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	inverse_affine_warp_sampler_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.pixel_in(pixel_in), .out_row(out_row), .out_col(out_col),
		.res_valid(res_valid), .res_ready(res_ready), .pixel_out(pixel_out),
		.src_col(src_col), .src_row(src_row), .singular_map(singular_map)
	);

	iaws_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.pixel_in(pixel_in), .out_row(out_row), .out_col(out_col),
		.res_valid(res_valid), .res_ready(res_ready), .pixel_out(pixel_out),
		.src_col(src_col), .src_row(src_row), .singular_map(singular_map),
		.errors(errors), .pending(pending)
	);

	// Result side: random stall bursts, always ready once quiet.
	initial begin
		res_ready <= 1'b0;
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// One input transaction. Valid only drops when a gap follows, so it is never
	// lowered and raised within the same step.
	task automatic send(iaws_pkg::req_t kind, logic [7:0] pix, logic [5:0] row,
		logic [5:0] col);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		pixel_in <= pix;
		out_row <= row;
		out_col <= col;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic sample_at(logic [5:0] row, logic [5:0] col);
		send(iaws_pkg::REQ_SAMPLE, 8'($urandom), row, col);
	endtask

	// Wait until every sample has come back; optionally let the core settle too.
	task automatic wait_results(bit settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		if (settle) repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(iaws_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	function automatic int eff_dim(logic [7:0] v);
		if (v == 0) return 1;
		return (v > 128) ? 128 : int'(v);
	endfunction

	function automatic logic [31:0] rand_q(int span);
		return 32'($urandom_range(0, 2 * span) - span);
	endfunction

	// Writes all eight registers for one phase, then reloads a whole frame so that
	// no sample can read a store entry that was never loaded.
	task automatic setup_phase(int ph);
		logic [31:0] c [6];
		logic [7:0]  w, h;
		int          n;
		case (ph)
			0: begin w = 8'd8; h = 8'd8; end
			1: begin w = 8'd255; h = 8'd1; end     // saturates to full width
			2: begin w = 8'd0; h = 8'd255; end     // one column, full height
			3: begin w = 8'd1; h = 8'd1; end
			4: begin w = 8'd128; h = 8'd1; end
			default: begin
				w = 8'($urandom_range(1, 8));
				h = 8'($urandom_range(1, 6));
			end
		endcase
		case (ph % 6)
			0: c = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
			1: c = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			2: begin
				// singular: second row zero, or both rows equal
				c = '{$urandom, $urandom, $urandom, 0, 0, $urandom};
				if ($urandom_range(0, 1)) c = '{32'h8000_0000, 32'h8000_0000,
					32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
			end
			3: c = '{32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000};
			4: c = '{rand_q(1 << 17), rand_q(1 << 17), rand_q(1 << 22),
				rand_q(1 << 17), rand_q(1 << 17), rand_q(1 << 22)};
			default: c = '{rand_q(1 << 16), rand_q(1 << 16), rand_q(1 << 20),
				rand_q(1 << 16), rand_q(1 << 16), rand_q(1 << 20)};
		endcase
		if (ph == 0) c = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
		write_reg(iaws_pkg::REG_A11, c[0]);
		write_reg(iaws_pkg::REG_A12, c[1]);
		write_reg(iaws_pkg::REG_B1, c[2]);
		write_reg(iaws_pkg::REG_A21, c[3]);
		write_reg(iaws_pkg::REG_A22, c[4]);
		write_reg(iaws_pkg::REG_B2, c[5]);
		write_reg(iaws_pkg::REG_SRC_W, {24'($urandom), w});
		write_reg(iaws_pkg::REG_SRC_H, {24'($urandom), h});
		cfg_valid <= 1'b0;
		n = eff_dim(w) * eff_dim(h);
		repeat (n) send(iaws_pkg::REQ_LOAD, 8'($urandom), 6'($urandom), 6'($urandom));
	endtask

	initial begin
		int n_rand;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		req_type <= iaws_pkg::REQ_LOAD;
		pixel_in <= '0;
		out_row <= '0;
		out_col <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == NUM_PHASES - 1) quiet = 1'b1;
			setup_phase(ph);
			if (ph == 0) begin
				// directed corners, saturation of the output coordinate, extreme pixels
				sample_at(6'd0, 6'd0);
				sample_at(6'd47, 6'd39);
				sample_at(6'd63, 6'd63);
				sample_at(6'd0, 6'd63);
				sample_at(6'd63, 6'd0);
				sample_at(6'd15, 6'd15);
				sample_at(6'd16, 6'd16);
				send(iaws_pkg::REQ_LOAD, 8'hff, 6'h3f, 6'h3f);
				send(iaws_pkg::REQ_LOAD, 8'h00, 6'h00, 6'h00);
				sample_at(6'd0, 6'd0);
				sample_at(6'd0, 6'd1);
				sample_at(6'd1, 6'd0);
				sample_at(6'd48, 6'd40);
				sample_at(6'd7, 6'd9);
			end
			n_rand = (ph == 0) ? 30 : 40;
			for (int i = 0; i < n_rand; i++) begin
				// hold the sender once until the core is empty
				if (ph == 5 && i == n_rand / 2) wait_results(1'b0);
				if ($urandom_range(0, 3) == 0)
					send(iaws_pkg::REQ_LOAD, 8'($urandom), 6'($urandom), 6'($urandom));
				else if ($urandom_range(0, 7) == 0)
					sample_at(6'($urandom), 6'($urandom));
				else
					sample_at(6'($urandom_range(0, 47)), 6'($urandom_range(0, 39)));
			end
			wait_results(1'b1);
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

### sim.f
+incdir+sv
sv/iaws_pkg.sv
sv/iaws_front.sv
sv/iaws_back.sv
sv/inverse_affine_warp_sampler_core.sv
tb/iaws_checker.sv
tb/tb_inverse_affine_warp_sampler_core.sv
